// ===== src/asup_pkg.sv =====
// ----------------------------------------------------------------------------
// asup_pkg: shared types and constants of the arming supervisor
// Field widths, error and message codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package asup_pkg;

	localparam int CHANNELS = 8;      // watchdog channels kept
	localparam int FEED_W   = 8;      // feed mask and channel enable width
	localparam int DT_W     = 8;      // elapsed time per tick
	localparam int PWR_W    = 3;
	localparam int TIME_W   = 12;     // hold time and watchdog timeout
	localparam int CNT_W    = 13;     // hold and silence counters
	localparam int ERR_W    = 3;
	localparam int MSG_W    = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = TIME_W;

	localparam int IN_BITS   = 26;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_BITS  = 18;
	localparam int OUT_TDATA_W = 24;

	// Arm error codes, in falling priority from POWER down.
	localparam logic [ERR_W-1:0] ERR_OK    = 3'd0;
	localparam logic [ERR_W-1:0] ERR_IMU   = 3'd1;
	localparam logic [ERR_W-1:0] ERR_BARO  = 3'd2;
	localparam logic [ERR_W-1:0] ERR_MPU   = 3'd3;
	localparam logic [ERR_W-1:0] ERR_POWER = 3'd4;

	// Message events.
	localparam logic [MSG_W-1:0] MSG_NONE   = 3'd0;
	localparam logic [MSG_W-1:0] MSG_OK     = 3'd1;
	localparam logic [MSG_W-1:0] MSG_FAIL   = 3'd2;
	localparam logic [MSG_W-1:0] MSG_POWER  = 3'd3;
	localparam logic [MSG_W-1:0] MSG_LOCKED = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_POWER_OK_MAX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WDOG_TIMEOUT = 2'd2;

	localparam logic [PWR_W-1:0]  POWER_OK_MAX_RST = 3'd2;
	localparam logic [TIME_W-1:0] HOLD_TIME_RST    = 12'd1500;
	localparam logic [TIME_W-1:0] WDOG_TIMEOUT_RST = 12'd500;

	// One tick request, last field in the lowest bits.
	typedef struct packed {
		logic [FEED_W-1:0] feed_mask;
		logic              unlock_button;
		logic              imu_ready;
		logic              baro_ok;
		logic              gyro_ok;
		logic              accel_ok;
		logic              save_pending;
		logic [PWR_W-1:0]  power_level;
		logic              sys_started;
		logic [DT_W-1:0]   elapsed_ms;
	} tick_t;

	// Arm side of one result.
	typedef struct packed {
		logic             imu_error_latch;
		logic             baro_error_latch;
		logic [MSG_W-1:0] message;
		logic [ERR_W-1:0] arm_error;
		logic             arm_request;
		logic             armed;
	} arm_status_t;

endpackage

`default_nettype wire

// ===== src/asup_arm.sv =====
// ----------------------------------------------------------------------------
// asup_arm: arm state machine, error checks and unlock button timer
// Computes the post-tick arm status and stores it when a tick is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module asup_arm (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           step,
	input  asup_pkg::tick_t               tick,
	input  wire [asup_pkg::PWR_W-1:0]     power_ok_max,
	input  wire [asup_pkg::TIME_W-1:0]    hold_time_ms,
	output asup_pkg::arm_status_t         status_nxt
);
	import asup_pkg::*;

	logic             request_q, armed_q, baro_q, mpu_q;
	logic [ERR_W-1:0] error_q;
	logic [CNT_W-1:0] hold_q;

	logic             request_d, armed_d, baro_d, mpu_d;
	logic [ERR_W-1:0] error_d;
	logic [CNT_W-1:0] hold_d, hold_sum;
	logic [MSG_W-1:0] msg_d;
	logic             req_after_arm;

	assign hold_sum = hold_q + CNT_W'(tick.elapsed_ms);

	always_comb begin
		request_d     = request_q;
		armed_d       = armed_q;
		baro_d        = baro_q;
		mpu_d         = mpu_q;
		error_d       = error_q;
		hold_d        = hold_q;
		msg_d         = MSG_NONE;
		req_after_arm = request_q;
		if (tick.sys_started) begin
			// Prioritized precondition check; latches only set past the power check.
			if (tick.power_level > power_ok_max || tick.save_pending) begin
				error_d = ERR_POWER;
			end else if (!(tick.accel_ok && tick.gyro_ok)) begin
				error_d = ERR_MPU;
				mpu_d   = 1'b1;
			end else if (!tick.baro_ok) begin
				error_d = ERR_BARO;
				baro_d  = 1'b1;
			end else if (!tick.imu_ready) begin
				error_d = ERR_IMU;
			end else begin
				error_d = ERR_OK;
			end

			if (!armed_q) begin
				if (request_q) begin
					if (error_d == ERR_OK) begin
						armed_d = 1'b1;
						msg_d   = MSG_OK;
					end else begin
						req_after_arm = 1'b0;
						msg_d = (error_d == ERR_POWER) ? MSG_POWER : MSG_FAIL;
					end
				end
			end else begin
				if (!request_q)
					msg_d = MSG_LOCKED;
				armed_d = request_q;
			end

			// The toggle lands after the arm decision, so it acts next tick.
			request_d = req_after_arm;
			if (tick.unlock_button) begin
				if (hold_sum > CNT_W'(hold_time_ms)) begin
					hold_d    = '0;
					request_d = ~req_after_arm;
				end else begin
					hold_d = hold_sum;
				end
			end else begin
				hold_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_q <= 1'b0;
			armed_q   <= 1'b0;
			baro_q    <= 1'b0;
			mpu_q     <= 1'b0;
			error_q   <= ERR_OK;
			hold_q    <= '0;
		end else if (step) begin
			request_q <= request_d;
			armed_q   <= armed_d;
			baro_q    <= baro_d;
			mpu_q     <= mpu_d;
			error_q   <= error_d;
			hold_q    <= hold_d;
		end
	end

	assign status_nxt.armed            = armed_d;
	assign status_nxt.arm_request      = request_d;
	assign status_nxt.arm_error        = error_d;
	assign status_nxt.message          = msg_d;
	assign status_nxt.baro_error_latch = baro_d;
	assign status_nxt.imu_error_latch  = mpu_d;

endmodule

`default_nettype wire

// ===== src/asup_watchdog.sv =====
// ----------------------------------------------------------------------------
// asup_watchdog: per-channel silence counters and enable bits
// Each channel runs its own counter; a feed clears it, a timeout drops enable.
// ----------------------------------------------------------------------------
`default_nettype none

module asup_watchdog (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           step,
	input  wire                           sys_started,
	input  wire [asup_pkg::DT_W-1:0]      elapsed_ms,
	input  wire [asup_pkg::FEED_W-1:0]    feed_mask,
	input  wire [asup_pkg::TIME_W-1:0]    timeout_ms,
	output logic [asup_pkg::FEED_W-1:0]   enable_nxt
);
	import asup_pkg::*;

	logic [CHANNELS-1:0] en_d;

	for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
		logic [CNT_W-1:0] cnt_q, cnt_fed, cnt_d;
		logic             en_q, en_nxt;
		logic             fed;

		if (i < FEED_W) begin : g_feed
			assign fed = feed_mask[i];
		end else begin : g_nofeed
			assign fed = 1'b0;
		end

		always_comb begin
			cnt_fed = fed ? '0 : cnt_q;
			cnt_d   = cnt_q;
			en_nxt  = en_q;
			if (sys_started) begin
				if (cnt_fed < CNT_W'(timeout_ms)) begin
					cnt_d  = cnt_fed + CNT_W'(elapsed_ms);
					en_nxt = 1'b1;
				end else begin
					cnt_d  = cnt_fed;
					en_nxt = 1'b0;
				end
			end
		end

		assign en_d[i] = en_nxt;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q <= '0;
				en_q  <= 1'b0;
			end else if (step) begin
				cnt_q <= cnt_d;
				en_q  <= en_nxt;
			end
		end
	end

	for (genvar j = 0; j < FEED_W; j++) begin : g_out
		if (j < CHANNELS) begin : g_live
			assign enable_nxt[j] = en_d[j];
		end else begin : g_absent
			assign enable_nxt[j] = 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== src/arming_supervisor_with_channel_watchdog.sv =====
// ----------------------------------------------------------------------------
// arming_supervisor_with_channel_watchdog: arm supervisor and channel watchdog
// Takes one control tick per request and returns one status result per tick.
// ----------------------------------------------------------------------------
// Each tick passes through the input register, then the state update and the
// result register, before its result can be taken by the receiver.
// Throughput: one tick per cycle; the arm and watchdog state updates never
// hold a tick back, so the only limit is the output handshake.
// Reset (arst_n low, asynchronous): all state clears, the configuration
// returns to power_ok_max 2, hold time 1500 ms and watchdog timeout 500 ms.
`default_nettype none

module arming_supervisor_with_channel_watchdog (
	input  wire                                clk,
	input  wire                                arst_n,
	// Tick requests.
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	// tdata from bit 0: elapsed_ms[7:0], sys_started, power_level[2:0], save_pending,
	// accel_ok, gyro_ok, baro_ok, imu_ready, unlock_button, feed_mask[7:0], zero pad
	input  wire  [asup_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// Status results.
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	// tdata from bit 0: armed, arm_request, arm_error[2:0], message[2:0],
	// channel_enable[7:0], baro_error_latch, imu_error_latch, zero pad
	output logic [asup_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// Configuration writes.
	input  wire                                cfg_we,
	input  wire  [asup_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [asup_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import asup_pkg::*;

	// Configuration registers.
	logic [PWR_W-1:0]  power_ok_max_q;
	logic [TIME_W-1:0] hold_time_q;
	logic [TIME_W-1:0] wdog_timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_ok_max_q <= POWER_OK_MAX_RST;
			hold_time_q    <= HOLD_TIME_RST;
			wdog_timeout_q <= WDOG_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POWER_OK_MAX: power_ok_max_q <= cfg_data[PWR_W-1:0];
				REG_HOLD_TIME:    hold_time_q    <= cfg_data;
				REG_WDOG_TIMEOUT: wdog_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register. A tick in it advances whenever the result register is
	// free or being emptied in the same cycle, so the state sees one tick per
	// cycle. A waiting result stalls the input only once this register is
	// also holding a tick.
	logic  valid_s1;
	tick_t tick_s1;
	logic  advance;

	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			tick_s1 <= tick_t'(s_axis_tdata[IN_BITS-1:0]);
	end

	// The state lives in the two units below; each reports the post-tick
	// values, which are committed to its state and captured as the result on
	// the same edge.
	arm_status_t      arm_nxt;
	logic [FEED_W-1:0] enable_nxt;

	asup_arm u_arm (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.tick         (tick_s1),
		.power_ok_max (power_ok_max_q),
		.hold_time_ms (hold_time_q),
		.status_nxt   (arm_nxt)
	);

	asup_watchdog u_watchdog (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.sys_started (tick_s1.sys_started),
		.elapsed_ms  (tick_s1.elapsed_ms),
		.feed_mask   (tick_s1.feed_mask),
		.timeout_ms  (wdog_timeout_q),
		.enable_nxt  (enable_nxt)
	);

	// Result register.
	logic [OUT_BITS-1:0] result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tvalid <= 1'b0;
		else if (advance)
			m_axis_tvalid <= 1'b1;
		else if (m_axis_tready)
			m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= {arm_nxt.imu_error_latch, arm_nxt.baro_error_latch, enable_nxt,
				arm_nxt.message, arm_nxt.arm_error, arm_nxt.arm_request, arm_nxt.armed};
	end

	assign m_axis_tdata = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, result_s2};

endmodule

`default_nettype wire

// ===== tb/arming_supervisor_with_channel_watchdog_tb.sv =====
// ----------------------------------------------------------------------------
// arming_supervisor_with_channel_watchdog_tb: self-checking arm supervisor bench
// Streams tick requests into the block, predicts every status result in step
// with the accepted ticks and compares each returned result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module arming_supervisor_with_channel_watchdog_tb;

	import asup_pkg::*;

	// A status result as it sits in m_axis_tdata, lowest field last.
	typedef struct packed {
		logic              imu_latch;
		logic              baro_latch;
		logic [FEED_W-1:0] chan_enable;
		logic [MSG_W-1:0]  message;
		logic [ERR_W-1:0]  arm_error;
		logic              arm_request;
		logic              armed;
	} status_t;

	// Without a handshake for this many cycles the run is declared hung. The
	// longest legal quiet stretch is the receiver hold-off below plus a few
	// random gaps, so this leaves a wide margin.
	localparam int STALL_LIMIT     = 4000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 4;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	arming_supervisor_with_channel_watchdog i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// Ticks waiting to be offered, and the status results still owed by the
	// block for ticks it has already taken, oldest first.
	tick_t   tick_queue[$];
	status_t status_queue[$];

	// Pacing of both sides, set by the stimulus process between phases.
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	bit          squeeze_on     = 1'b0;

	int unsigned mismatches   = 0;
	int unsigned results_seen = 0;
	int unsigned idle_cycles  = 0;

	// Shadow of the supervisor: limits as last written, and the arm, latch,
	// button and watchdog state as the block should hold it right now.
	logic [PWR_W-1:0]  lim_power;
	logic [TIME_W-1:0] lim_hold_ms;
	logic [TIME_W-1:0] lim_quiet_ms;
	logic              want_arm;
	logic              is_armed;
	logic [ERR_W-1:0]  last_err;
	logic              baro_stuck;
	logic              imu_stuck;
	logic [CNT_W-1:0]  press_ms;
	logic [CNT_W-1:0]  quiet_ms [CHANNELS];
	logic [FEED_W-1:0] live_mask;

	initial begin
		lim_power    = POWER_OK_MAX_RST;
		lim_hold_ms  = HOLD_TIME_RST;
		lim_quiet_ms = WDOG_TIMEOUT_RST;
		want_arm     = 1'b0;
		is_armed     = 1'b0;
		last_err     = ERR_OK;
		baro_stuck   = 1'b0;
		imu_stuck    = 1'b0;
		press_ms     = '0;
		live_mask    = '0;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			quiet_ms[ch] = '0;
		end
	end

	// Advances the shadow state by one tick and returns the status the block
	// must report for it. A tick with sys_started low leaves everything alone.
	function automatic status_t advance_supervisor(input tick_t t);
		status_t          s;
		logic [MSG_W-1:0] msg;
		int               ch;
		msg = MSG_NONE;
		if (t.sys_started) begin
			// Power and saving come first; sensor latches only set once power passes.
			if (t.power_level > lim_power || t.save_pending) begin
				last_err = ERR_POWER;
			end else if (!(t.accel_ok && t.gyro_ok)) begin
				last_err  = ERR_MPU;
				imu_stuck = 1'b1;
			end else if (!t.baro_ok) begin
				last_err   = ERR_BARO;
				baro_stuck = 1'b1;
			end else begin
				last_err = t.imu_ready ? ERR_OK : ERR_IMU;
			end

			// The arm decision uses the request as it stood before this tick's
			// button handling, so a fresh toggle only acts on the next tick.
			if (!is_armed) begin
				if (want_arm) begin
					if (last_err == ERR_OK) begin
						is_armed = 1'b1;
						msg      = MSG_OK;
					end else begin
						want_arm = 1'b0;
						msg      = (last_err == ERR_POWER) ? MSG_POWER : MSG_FAIL;
					end
				end
			end else begin
				if (!want_arm) begin
					msg = MSG_LOCKED;
				end
				is_armed = want_arm;
			end

			if (t.unlock_button) begin
				press_ms = press_ms + t.elapsed_ms;
				if (press_ms > lim_hold_ms) begin
					press_ms = '0;
					want_arm = ~want_arm;
				end
			end else begin
				press_ms = '0;
			end

			// A feed zeroes the channel's silence first; a channel that has
			// reached the timeout drops its enable and stops counting.
			for (ch = 0; ch < CHANNELS; ch++) begin
				if (t.feed_mask[ch]) begin
					quiet_ms[ch] = '0;
				end
				if (quiet_ms[ch] < lim_quiet_ms) begin
					quiet_ms[ch]  = quiet_ms[ch] + t.elapsed_ms;
					live_mask[ch] = 1'b1;
				end else begin
					live_mask[ch] = 1'b0;
				end
			end
		end
		s.imu_latch   = imu_stuck;
		s.baro_latch  = baro_stuck;
		s.chan_enable = live_mask;
		s.message     = msg;
		s.arm_error   = last_err;
		s.arm_request = want_arm;
		s.armed       = is_armed;
		return s;
	endfunction

	// One line per mismatch, and a running count.
	task automatic flag_mismatch(input string what, input int unsigned got_v,
			input int unsigned want_v);
		$display("result %0d: %s got %0d expected %0d", results_seen, what, got_v, want_v);
		mismatches++;
	endtask

	// Driver. A request that the block takes is run through the shadow at once,
	// so the owed status is queued before the block can possibly return it.
	// The next tick is offered in the same step with a single assignment to
	// tvalid, so a valid that stays high is never dropped and raised again.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				status_queue.push_back(advance_supervisor(s_axis_tdata[IN_BITS-1:0]));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {{(IN_TDATA_W-IN_BITS){1'b0}}, tick_queue.pop_front()};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver. When a squeeze phase starts it holds tready low for a long
	// stretch while the driver keeps offering, so the block backs up and has
	// to stall its input; otherwise it stalls at random at the phase's rate.
	int unsigned hold_off_left = 0;
	bit          hold_off_done = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (squeeze_on && !hold_off_done) begin
			hold_off_done <= 1'b1;
			hold_off_left <= HOLD_OFF_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_off_left > 0) begin
			hold_off_left <= hold_off_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: every accepted status is checked against the oldest one owed.
	status_t seen_status;
	status_t due_status;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_status = m_axis_tdata[OUT_BITS-1:0];
			if (status_queue.size() == 0) begin
				flag_mismatch("status with no tick pending, tdata", m_axis_tdata, 0);
			end else begin
				due_status = status_queue.pop_front();
				if (seen_status.armed != due_status.armed)
					flag_mismatch("armed", seen_status.armed, due_status.armed);
				if (seen_status.arm_request != due_status.arm_request)
					flag_mismatch("arm_request", seen_status.arm_request, due_status.arm_request);
				if (seen_status.arm_error != due_status.arm_error)
					flag_mismatch("arm_error", seen_status.arm_error, due_status.arm_error);
				if (seen_status.message != due_status.message)
					flag_mismatch("message", seen_status.message, due_status.message);
				if (seen_status.chan_enable != due_status.chan_enable)
					flag_mismatch("channel_enable", seen_status.chan_enable,
						due_status.chan_enable);
				if (seen_status.baro_latch != due_status.baro_latch)
					flag_mismatch("baro_error_latch", seen_status.baro_latch,
						due_status.baro_latch);
				if (seen_status.imu_latch != due_status.imu_latch)
					flag_mismatch("imu_error_latch", seen_status.imu_latch, due_status.imu_latch);
			end
			results_seen++;
		end
	end

	// Hang detector: counts cycles in which neither side completes a handshake.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Register write; the block is idle whenever this is called, so the shadow
	// limits can follow at once.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_POWER_OK_MAX: begin
				lim_power = value[PWR_W-1:0];
			end
			REG_HOLD_TIME: begin
				lim_hold_ms = value;
			end
			REG_WDOG_TIMEOUT: begin
				lim_quiet_ms = value;
			end
			default: begin
			end
		endcase
	endtask

	// Waits until every queued tick is taken and every owed status is back,
	// then lets the two-stage pipe settle before anything is reconfigured.
	task automatic drain_and_settle();
		do @(negedge clk);
		while (tick_queue.size() != 0 || s_axis_tvalid || status_queue.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// A healthy, started tick on full power; directed cases edit one or more fields.
	function automatic tick_t fit_tick(input logic [DT_W-1:0] dt, input logic button,
			input logic [FEED_W-1:0] feed);
		tick_t t;
		t.elapsed_ms    = dt;
		t.sys_started   = 1'b1;
		t.power_level   = '0;
		t.save_pending  = 1'b0;
		t.accel_ok      = 1'b1;
		t.gyro_ok       = 1'b1;
		t.baro_ok       = 1'b1;
		t.imu_ready     = 1'b1;
		t.unlock_button = button;
		t.feed_mask     = feed;
		return t;
	endfunction

	// A plausible tick: mostly started, healthy and within the power limit,
	// with channels fed now and then so enables both drop out and recover.
	function automatic tick_t shaped_tick(input logic button);
		tick_t t;
		int    ch;
		t.elapsed_ms    = DT_W'($urandom_range(255));
		t.sys_started   = ($urandom_range(99) < 97);
		t.power_level   = ($urandom_range(99) < 85) ? PWR_W'($urandom_range(lim_power))
			: PWR_W'($urandom_range(7));
		t.save_pending  = ($urandom_range(99) < 4);
		t.accel_ok      = ($urandom_range(99) < 94);
		t.gyro_ok       = ($urandom_range(99) < 94);
		t.baro_ok       = ($urandom_range(99) < 94);
		t.imu_ready     = ($urandom_range(99) < 93);
		t.unlock_button = button;
		for (ch = 0; ch < FEED_W; ch++) begin
			t.feed_mask[ch] = ($urandom_range(99) < 30);
		end
		return t;
	endfunction

	// Most of the random traffic is button presses of random length followed
	// by a short release, which is what it takes to toggle the request and
	// walk the arm machine; the rest is raw noise over every field.
	task automatic queue_random_ticks(input int count);
		int          burst;
		int          k;
		logic [31:0] raw;
		tick_t       t;
		while (count > 0) begin
			if ($urandom_range(99) < 70) begin
				burst = $urandom_range(1, 30);
				for (k = 0; k < burst && count > 0; k++) begin
					tick_queue.push_back(shaped_tick(1'b1));
					count--;
				end
				burst = $urandom_range(1, 3);
				for (k = 0; k < burst && count > 0; k++) begin
					tick_queue.push_back(shaped_tick(1'b0));
					count--;
				end
			end else begin
				burst = $urandom_range(1, 6);
				for (k = 0; k < burst && count > 0; k++) begin
					raw = $urandom();
					t   = raw[IN_BITS-1:0];
					tick_queue.push_back(t);
					count--;
				end
			end
		end
	endtask

	// One random phase: new limits while idle, new pacing, then the ticks.
	task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input bit squeeze, input int unsigned power_max, input int unsigned hold_ms,
			input int unsigned quiet_limit_ms, input int count);
		write_reg(REG_POWER_OK_MAX, CFG_DATA_W'(power_max));
		write_reg(REG_HOLD_TIME, CFG_DATA_W'(hold_ms));
		write_reg(REG_WDOG_TIMEOUT, CFG_DATA_W'(quiet_limit_ms));
		@(negedge clk);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		squeeze_on     = squeeze;
		queue_random_ticks(count);
		drain_and_settle();
		squeeze_on = 1'b0;
	endtask

	initial begin
		tick_t t;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Power limit and watchdog timeout keep their reset
		// values; a short hold time lets one long press toggle the request.
		write_reg(REG_HOLD_TIME, CFG_DATA_W'(200));
		@(negedge clk);
		// Start low with every other field set: nothing may move.
		t = fit_tick(8'd255, 1'b1, 8'hFF);
		t.sys_started  = 1'b0;
		t.power_level  = 3'd7;
		t.save_pending = 1'b1;
		tick_queue.push_back(t);
		// All channels fed with no time passing, then a press that toggles the
		// request, an arm, a press that drops it and the lock message.
		tick_queue.push_back(fit_tick(8'd0, 1'b0, 8'hFF));
		tick_queue.push_back(fit_tick(8'd255, 1'b1, 8'h00));
		tick_queue.push_back(fit_tick(8'd10, 1'b0, 8'h0F));
		tick_queue.push_back(fit_tick(8'd255, 1'b1, 8'h00));
		tick_queue.push_back(fit_tick(8'd10, 1'b0, 8'h00));
		// Each refusal reason, each after a fresh request: power low, save
		// pending, accelerometer, barometer, inertial data not ready, and a
		// gyro fault hidden behind the lowest power level.
		tick_queue.push_back(fit_tick(8'd255, 1'b1, 8'hF0));
		t = fit_tick(8'd5, 1'b0, 8'h00);
		t.power_level = 3'd3;
		tick_queue.push_back(t);
		tick_queue.push_back(fit_tick(8'd255, 1'b1, 8'h00));
		t = fit_tick(8'd5, 1'b0, 8'h00);
		t.save_pending = 1'b1;
		tick_queue.push_back(t);
		tick_queue.push_back(fit_tick(8'd255, 1'b1, 8'h00));
		t = fit_tick(8'd5, 1'b0, 8'h00);
		t.accel_ok = 1'b0;
		tick_queue.push_back(t);
		tick_queue.push_back(fit_tick(8'd255, 1'b1, 8'h00));
		t = fit_tick(8'd5, 1'b0, 8'h00);
		t.baro_ok = 1'b0;
		tick_queue.push_back(t);
		tick_queue.push_back(fit_tick(8'd255, 1'b1, 8'h00));
		t = fit_tick(8'd5, 1'b0, 8'h00);
		t.imu_ready = 1'b0;
		tick_queue.push_back(t);
		tick_queue.push_back(fit_tick(8'd255, 1'b1, 8'h00));
		t = fit_tick(8'd5, 1'b0, 8'h00);
		t.gyro_ok     = 1'b0;
		t.power_level = 3'd7;
		tick_queue.push_back(t);
		// The hold time must be exceeded, not just reached.
		tick_queue.push_back(fit_tick(8'd100, 1'b1, 8'h00));
		tick_queue.push_back(fit_tick(8'd100, 1'b1, 8'h00));
		tick_queue.push_back(fit_tick(8'd1, 1'b1, 8'h00));
		tick_queue.push_back(fit_tick(8'd0, 1'b0, 8'hAA));
		// Let the silence counters run past the timeout, then feed half.
		tick_queue.push_back(fit_tick(8'd255, 1'b0, 8'h00));
		tick_queue.push_back(fit_tick(8'd255, 1'b0, 8'h00));
		tick_queue.push_back(fit_tick(8'd255, 1'b0, 8'h55));
		drain_and_settle();

		// Random phases: reset limits at full rate, lowest limits with a slow
		// sender, highest limits with a slow receiver, then mixed settings,
		// a squeeze phase and a final full-range phase.
		run_phase(0, 0, 1'b0, 2, 1500, 500, 250);
		run_phase(76, 0, 1'b0, 0, 0, 0, 250);
		run_phase(0, 76, 1'b0, 7, 4000, 4000, 250);
		run_phase(29, 29, 1'b0, $urandom_range(7), $urandom_range(800),
			$urandom_range(4000), 250);
		run_phase(0, 0, 1'b1, 3, 600, 300, 200);
		run_phase(0, 0, 1'b0, $urandom_range(7), $urandom_range(4000),
			$urandom_range(4000), 250);

		if (status_queue.size() != 0) begin
			flag_mismatch("statuses never returned", status_queue.size(), 0);
		end
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/asup_pkg.sv
src/asup_arm.sv
src/asup_watchdog.sv
src/arming_supervisor_with_channel_watchdog.sv
tb/arming_supervisor_with_channel_watchdog_tb.sv
